/* rtl/indexed_doubly_linked_list_macros.svh */
// Assertion macros shared by the checker of the indexed linked list block.
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define IDLL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define IDLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/idll_pkg.sv */
// Shared types and codes of the indexed doubly linked list block.
package idll_pkg;

    localparam int ID_W = 10;

    typedef enum logic [1:0] {
        ACT_INS_AFTER  = 2'd0,
        ACT_INS_BEFORE = 2'd1,
        ACT_REMOVE     = 2'd2,
        ACT_QUERY      = 2'd3
    } action_t;

    localparam logic [1:0] STS_DONE   = 2'd0;
    localparam logic [1:0] STS_ABSENT = 2'd1;
    localparam logic [1:0] STS_REJECT = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;   // write one reset entry of the link tables
        logic accept;  // capture a transaction and read the tables
        logic exec;    // decide and do the first table write
        logic finish;  // second table write and load the result
    } idll_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // clearing pass at its last entry
        logic out_free;    // result register can take a new result
    } idll_sts_t;

endpackage

/* rtl/idll_ctrl.sv */
// Sequencer of the indexed doubly linked list: clearing pass and item steps.
module idll_ctrl import idll_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  idll_sts_t sts,
    output idll_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    // Decode commands
    always_comb begin
        cmd.clear  = (state_reg == ST_CLEAR);
        cmd.accept = s_ready_reg && s_valid;
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.finish = (state_reg == ST_FINISH) && sts.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

/* rtl/idll_dp.sv */
// Datapath of the indexed doubly linked list: link tables, head and result register.
module idll_dp import idll_pkg::*; #(
    parameter int ENTRY_COUNT = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  idll_cmd_t       cmd,
    output idll_sts_t       sts,
    input  logic [1:0]      s_action,
    input  logic [ID_W-1:0] s_subject_id,
    input  logic [ID_W-1:0] s_anchor_id,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [ID_W-1:0] m_head_id,
    output logic [ID_W-1:0] m_prev_id,
    output logic [ID_W-1:0] m_next_id,
    output logic            m_listed
);

    localparam int DEPTH  = (ENTRY_COUNT < (1 << ID_W)) ? ENTRY_COUNT : (1 << ID_W);
    localparam int ADDR_W = $clog2(DEPTH);

    // Link tables and membership flags
    logic [ID_W-1:0] prev_mem [DEPTH];
    logic [ID_W-1:0] next_mem [DEPTH];
    logic            flag_mem [DEPTH];

    action_t         act_reg;
    logic [ID_W-1:0] subj_reg, anch_reg;
    logic [ID_W-1:0] subj_prev_reg, subj_next_reg, anch_prev_reg, anch_next_reg;
    logic            subj_flag_reg, anch_flag_reg;
    logic [ID_W-1:0] head_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic            m_valid_reg;
    logic [1:0]      m_status_reg;
    logic [ID_W-1:0] m_head_reg, m_prev_reg, m_next_reg;
    logic            m_listed_reg;

    logic              prev_we, next_we, flag_we, flag_wd;
    logic [ADDR_W-1:0] prev_wa, next_wa, flag_wa;
    logic [ID_W-1:0]   prev_wd, next_wd;

    logic [ADDR_W-1:0] subj_addr, anch_addr;
    logic              subj_ok, anch_ok, subj_listed, anch_listed;
    logic              is_ins, is_after, ins_ok, rem_ok;
    logic [ID_W-1:0]   nb_id;
    logic [1:0]        res_status;
    logic [ID_W-1:0]   res_prev, res_next;
    logic              res_listed;

    // Capture the transaction and read both ids from every table
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg       <= action_t'(s_action);
            subj_reg      <= s_subject_id;
            anch_reg      <= s_anchor_id;
            subj_prev_reg <= prev_mem[s_subject_id[ADDR_W-1:0]];
            subj_next_reg <= next_mem[s_subject_id[ADDR_W-1:0]];
            subj_flag_reg <= flag_mem[s_subject_id[ADDR_W-1:0]];
            anch_prev_reg <= prev_mem[s_anchor_id[ADDR_W-1:0]];
            anch_next_reg <= next_mem[s_anchor_id[ADDR_W-1:0]];
            anch_flag_reg <= flag_mem[s_anchor_id[ADDR_W-1:0]];
        end
    end

    // Decide on the captured item; links of listed entries are zero or listed
    always_comb begin
        subj_addr   = subj_reg[ADDR_W-1:0];
        anch_addr   = anch_reg[ADDR_W-1:0];
        subj_ok     = (subj_reg != '0) && (32'(subj_reg) < ENTRY_COUNT);
        anch_ok     = (anch_reg != '0) && (32'(anch_reg) < ENTRY_COUNT);
        subj_listed = subj_ok && subj_flag_reg;
        anch_listed = anch_ok && anch_flag_reg;
        is_after    = (act_reg == ACT_INS_AFTER);
        is_ins      = is_after || (act_reg == ACT_INS_BEFORE);
        ins_ok      = is_ins && anch_listed && subj_ok && !subj_flag_reg;
        rem_ok      = (act_reg == ACT_REMOVE) && subj_listed;
        nb_id       = is_after ? anch_next_reg : anch_prev_reg;
    end

    // Form the result fields of the item
    always_comb begin
        if (is_ins) begin
            res_status = ins_ok ? STS_DONE : STS_REJECT;
        end else begin
            res_status = subj_listed ? STS_DONE : STS_ABSENT;
        end
        if (ins_ok) begin
            res_listed = 1'b1;
            res_prev   = is_after ? anch_reg : nb_id;
            res_next   = is_after ? nb_id : anch_reg;
        end else if (rem_ok || !subj_listed) begin
            res_listed = 1'b0;
            res_prev   = '0;
            res_next   = '0;
        end else begin
            res_listed = 1'b1;
            res_prev   = subj_prev_reg;
            res_next   = subj_next_reg;
        end
    end

    // Select the table writes of each step
    always_comb begin
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        flag_we = 1'b0;
        flag_wa = '0;
        flag_wd = 1'b0;
        if (cmd.clear) begin
            prev_we = 1'b1;
            prev_wa = clr_cnt_reg;
            next_we = 1'b1;
            next_wa = clr_cnt_reg;
            flag_we = 1'b1;
            flag_wa = clr_cnt_reg;
            flag_wd = (clr_cnt_reg == ADDR_W'(1));
        end else if (cmd.exec) begin
            if (ins_ok) begin
                // link the new entry to its neighbors
                prev_we = 1'b1;
                prev_wa = subj_addr;
                prev_wd = is_after ? anch_reg : nb_id;
                next_we = 1'b1;
                next_wa = subj_addr;
                next_wd = is_after ? nb_id : anch_reg;
                flag_we = 1'b1;
                flag_wa = subj_addr;
                flag_wd = 1'b1;
            end else if (rem_ok) begin
                // bridge the neighbors over the removed entry
                prev_we = (subj_next_reg != '0);
                prev_wa = subj_next_reg[ADDR_W-1:0];
                prev_wd = subj_prev_reg;
                next_we = (subj_prev_reg != '0);
                next_wa = subj_prev_reg[ADDR_W-1:0];
                next_wd = subj_next_reg;
            end
        end else if (cmd.finish) begin
            if (ins_ok) begin
                // point the anchor and the far neighbor at the new entry
                prev_we = is_after ? (nb_id != '0) : 1'b1;
                prev_wa = is_after ? nb_id[ADDR_W-1:0] : anch_addr;
                prev_wd = subj_reg;
                next_we = is_after ? 1'b1 : (nb_id != '0);
                next_wa = is_after ? anch_addr : nb_id[ADDR_W-1:0];
                next_wd = subj_reg;
            end else if (rem_ok) begin
                // drop the removed entry's links and flag
                prev_we = 1'b1;
                prev_wa = subj_addr;
                next_we = 1'b1;
                next_wa = subj_addr;
                flag_we = 1'b1;
                flag_wa = subj_addr;
            end
        end
    end

    // Write the tables
    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (next_we) next_mem[next_wa] <= next_wd;
        if (flag_we) flag_mem[flag_wa] <= flag_wd;
    end

    // Advance the clearing pass and update the head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            head_reg    <= ID_W'(1);
        end else begin
            if (cmd.clear) clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            if (cmd.exec) begin
                if (ins_ok && !is_after && (head_reg == anch_reg)) begin
                    head_reg <= subj_reg;
                end else if (rem_ok && (head_reg == subj_reg)) begin
                    head_reg <= subj_next_reg;
                end
            end
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_status_reg <= res_status;
            m_head_reg   <= head_reg;
            m_prev_reg   <= res_prev;
            m_next_reg   <= res_next;
            m_listed_reg <= res_listed;
        end
    end

    always_comb begin
        sts.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_head_id = m_head_reg;
    assign m_prev_id = m_prev_reg;
    assign m_next_id = m_next_reg;
    assign m_listed  = m_listed_reg;

endmodule

/* rtl/indexed_doubly_linked_list.sv */
// Top level of the indexed doubly linked list: ids 1 to 1023 (and below ENTRY_COUNT)
// are kept in order in previous and next link tables with a head register, and the
// list starts out holding only entry 1. Each transaction inserts an id after or before
// a listed anchor, removes an id or queries one, and gives exactly one result with the
// status, the head, the subject's links and whether it is listed. An item goes through table
// reads at acceptance, a decision with the first link write, then the
// second link write with the result load; each link table has one write port, and an
// insert touches three link entries. The next transaction is taken while a result still
// waits; an item only stalls at its end while the previous result has not been taken.
// After reset a clearing pass resets all min(ENTRY_COUNT, 1024) table entries,
// with s_ready low.
module indexed_doubly_linked_list import idll_pkg::*; #(
    parameter int ENTRY_COUNT = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_action,
    input  logic [ID_W-1:0] s_subject_id,
    input  logic [ID_W-1:0] s_anchor_id,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [ID_W-1:0] m_head_id,
    output logic [ID_W-1:0] m_prev_id,
    output logic [ID_W-1:0] m_next_id,
    output logic            m_listed
);

    idll_cmd_t cmd;
    idll_sts_t sts;

    idll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    idll_dp #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_action     (s_action),
        .s_subject_id (s_subject_id),
        .s_anchor_id  (s_anchor_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_head_id    (m_head_id),
        .m_prev_id    (m_prev_id),
        .m_next_id    (m_next_id),
        .m_listed     (m_listed)
    );

endmodule

/* rtl/idll_checker.sv */
// Port-level checker of the indexed doubly linked list and its bind.
`include "indexed_doubly_linked_list_macros.svh"

module idll_checker import idll_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic [1:0]      s_action,
    input logic [ID_W-1:0] s_subject_id,
    input logic [ID_W-1:0] s_anchor_id,
    input logic            m_valid,
    input logic            m_ready,
    input logic [1:0]      m_status,
    input logic [ID_W-1:0] m_head_id,
    input logic [ID_W-1:0] m_prev_id,
    input logic [ID_W-1:0] m_next_id,
    input logic            m_listed
);

    // A stalled result holds
    `IDLL_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_head_id) && $stable(m_prev_id) && $stable(m_next_id) && $stable(m_listed))

    // One item at a time: ready drops after a transaction
    `IDLL_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // Only defined status codes
    `IDLL_ASSERT_IMPL(a_status_code, m_valid, m_status == STS_DONE || m_status == STS_ABSENT || m_status == STS_REJECT)

    // An unlisted subject shows no links
    `IDLL_ASSERT_IMPL(a_unlisted_links, m_valid && !m_listed, m_prev_id == '0 && m_next_id == '0)

    // An absent subject is never listed
    `IDLL_ASSERT_IMPL(a_absent_unlisted, m_valid && m_status == STS_ABSENT, !m_listed)

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (.*);
